// ----- sv/double_round_to_integral_macros.svh -----
// Assertion macros used by the checker file.
`ifndef DOUBLE_ROUND_TO_INTEGRAL_MACROS_SVH
`define DOUBLE_ROUND_TO_INTEGRAL_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define DRI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define DRI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dri_pkg.sv -----
`timescale 1ns / 1ps

package dri_pkg;

  // Operation codes.
  localparam logic [1:0] OP_FLOOR  = 2'd0;
  localparam logic [1:0] OP_CEIL   = 2'd1;
  localparam logic [1:0] OP_RINT   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Rounding modes for rint.
  localparam logic [1:0] RM_NEAREST = 2'd0;
  localparam logic [1:0] RM_ZERO    = 2'd1;
  localparam logic [1:0] RM_UP      = 2'd2;
  localparam logic [1:0] RM_DOWN    = 2'd3;

  // Magnitude rounding kinds.
  localparam logic [1:0] KIND_TRUNC   = 2'd0;
  localparam logic [1:0] KIND_UP      = 2'd1;
  localparam logic [1:0] KIND_NEAREST = 2'd2;

  localparam logic [10:0] EXP_BIAS  = 11'd1023;
  localparam logic [10:0] EXP_TWO52 = 11'd1075;
  localparam logic [10:0] EXP_ALL1  = 11'h7FF;
  localparam logic [62:0] ONE_MAG   = 63'h3FF0000000000000;

  localparam int unsigned STAGES = 3;

endpackage

// ----- sv/double_round_to_integral.sv -----
`timescale 1ns / 1ps

// Rounds an IEEE 754 binary64 operand to an integral binary64 value: floor,
// ceil, or rint under the configured rounding mode. One transaction can be
// taken every cycle while the output is not stalled. Stage one decodes the
// operand, picks the rounding kind and the weight of the lowest integer bit,
// stage two splits off the fraction and forms the rounding decision, and stage
// three adds the unit and patches sign and special cases. A stall at the
// output backs up through the stages without losing or repeating items.
// NaN, infinity and magnitudes of at least 2^52 pass through unchanged.
module double_round_to_integral
  import dri_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Rounding mode register write.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,
  // tdata: [1:0] opcode, [65:2] operand_bits, [71:66] zero.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  // tdata: [63:0] result_bits.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata
);

  logic [1:0] mode_q;

  assign cfg_ready_o = 1'b1;

  // Rounding mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= RM_NEAREST;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // Pipeline advance: each stage moves when the next one is free.
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  assign en3 = !v3_q || m_axis_tready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Stage 1: decode, select rounding kind, build the unit weight.
  logic [1:0]  op_in;
  logic [63:0] x_in;
  logic [10:0] e_in;
  logic [11:0] f_in;
  logic        pass_d, small_d, rdown_d;
  logic [1:0]  kind_d;
  logic [62:0] unit_d;

  assign op_in = s_axis_tdata[1:0];
  assign x_in  = s_axis_tdata[65:2];
  assign e_in  = x_in[62:52];
  assign f_in  = {1'b0, EXP_TWO52} - {1'b0, e_in};

  always_comb begin
    pass_d  = (e_in == EXP_ALL1) || (e_in >= EXP_TWO52) || (op_in == OP_UNUSED);
    small_d = (e_in < EXP_BIAS);
    rdown_d = (mode_q == RM_DOWN);
    unit_d  = small_d ? 63'd0 : (63'd1 << f_in[5:0]);
    case (op_in)
      OP_FLOOR: kind_d = x_in[63] ? KIND_UP : KIND_TRUNC;
      OP_CEIL:  kind_d = x_in[63] ? KIND_TRUNC : KIND_UP;
      default: begin
        case (mode_q)
          RM_NEAREST: kind_d = KIND_NEAREST;
          RM_ZERO:    kind_d = KIND_TRUNC;
          RM_UP:      kind_d = x_in[63] ? KIND_TRUNC : KIND_UP;
          default:    kind_d = x_in[63] ? KIND_UP : KIND_TRUNC;
        endcase
      end
    endcase
  end

  logic [63:0] x1_q;
  logic [1:0]  op1_q, kind1_q;
  logic        pass1_q, small1_q, rdown1_q;
  logic [62:0] unit1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      x1_q     <= x_in;
      op1_q    <= op_in;
      kind1_q  <= kind_d;
      pass1_q  <= pass_d;
      small1_q <= small_d;
      rdown1_q <= rdown_d;
      unit1_q  <= unit_d;
    end
  end

  // Stage 2: split fraction and decide the increment.
  logic [62:0] mag1, mask1, frac1, half1, clr_d;
  logic        odd1, inc_d;

  always_comb begin
    mag1  = x1_q[62:0];
    mask1 = unit1_q - 63'd1;
    frac1 = mag1 & mask1;
    half1 = unit1_q >> 1;
    clr_d = mag1 & ~mask1;
    odd1  = |(clr_d & unit1_q);
    if (small1_q) begin
      clr_d = 63'd0;
      case (kind1_q)
        KIND_UP:      inc_d = (mag1 != 63'd0);
        KIND_NEAREST: inc_d = (x1_q[62:52] == EXP_BIAS - 11'd1) && (mag1[51:0] != 52'd0);
        default:      inc_d = 1'b0;
      endcase
    end else begin
      case (kind1_q)
        KIND_UP:      inc_d = (frac1 != 63'd0);
        KIND_NEAREST: inc_d = (frac1 > half1) || ((frac1 == half1) && odd1);
        default:      inc_d = 1'b0;
      endcase
    end
  end

  logic [63:0] x2_q;
  logic [1:0]  op2_q;
  logic        pass2_q, small2_q, rdown2_q, inc2_q;
  logic [62:0] clr2_q, unit2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      x2_q     <= x1_q;
      op2_q    <= op1_q;
      pass2_q  <= pass1_q;
      small2_q <= small1_q;
      rdown2_q <= rdown1_q;
      inc2_q   <= inc_d;
      clr2_q   <= clr_d;
      unit2_q  <= unit1_q;
    end
  end

  // Stage 3: add the unit and patch sign and special cases.
  logic [62:0] rmag;
  logic [63:0] res_d;

  always_comb begin
    if (small2_q) begin
      rmag = inc2_q ? ONE_MAG : 63'd0;
    end else begin
      rmag = inc2_q ? clr2_q + unit2_q : clr2_q;
    end
    if (pass2_q) begin
      res_d = x2_q;
    end else if (op2_q == OP_RINT && rmag == 63'd0) begin
      res_d = {rdown2_q, 63'd0};
    end else begin
      res_d = {x2_q[63], rmag};
    end
  end

  logic [63:0] res_q;
  always_ff @(posedge clk_i) begin
    if (en3) res_q <= res_d;
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = res_q;

endmodule

// ----- sv/dri_checker.sv -----
`timescale 1ns / 1ps
`include "double_round_to_integral_macros.svh"

// Port-level checks of the rounding pipeline.
module dri_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // A stalled result holds its value.
  `DRI_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // With the output free, input is always taken.
  `DRI_ASSERT_IMPL(a_ready, clk_i, rst_ni, m_axis_tready, s_axis_tready,
    "input stalled while output is free")

  // A transaction taken while the output stays free shows up as a valid result.
  `DRI_ASSERT_IMPL(a_lat, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready ##1 m_axis_tready,
    ##1 m_axis_tvalid, "result missing after three cycles")

endmodule

bind double_round_to_integral dri_checker u_dri_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import dri_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // tdata: [1:0] opcode, [65:2] operand_bits, [71:66] zero.
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // tdata: [63:0] result_bits.
  logic [63:0] m_axis_tdata;

  double_round_to_integral dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Local copy of the rounding mode register.
  logic [1:0]  mode_shadow;
  logic [63:0] expected_rounded[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          timed_out = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Round a magnitude below 2^52 to an integer magnitude.
  function automatic logic [62:0] round_magnitude(logic [62:0] mag, logic [1:0] kind);
    logic [10:0] expo;
    logic [62:0] unit;
    logic [62:0] mask;
    logic [62:0] frac;
    logic [62:0] cleared;
    int unsigned nfrac;
    bit          bump;
    expo = mag[62:52];
    bump = 1'b0;
    if (expo < EXP_BIAS) begin
      if (kind == KIND_UP) bump = (mag != 0);
      else if (kind == KIND_NEAREST) bump = (expo == EXP_BIAS - 1) && (mag[51:0] != 0);
      return bump ? ONE_MAG : 63'd0;
    end
    nfrac = 32'(EXP_TWO52 - expo);
    unit = 63'd1 << nfrac;
    mask = unit - 63'd1;
    frac = mag & mask;
    cleared = mag & ~mask;
    if (kind == KIND_UP) begin
      bump = (frac != 0);
    end else if (kind == KIND_NEAREST) begin
      bump = (frac > (unit >> 1)) || (frac == (unit >> 1) && cleared[nfrac]);
    end
    return bump ? cleared + unit : cleared;
  endfunction

  // Integral value that the block should return for one operand.
  function automatic logic [63:0] rounded_value(logic [1:0] op, logic [63:0] x,
                                                logic [1:0] mode);
    logic        sgn;
    logic [10:0] expo;
    logic [1:0]  kind;
    logic [62:0] mag;
    sgn = x[63];
    expo = x[62:52];
    if (expo == EXP_ALL1 || expo >= EXP_TWO52 || !(op inside {OP_FLOOR, OP_CEIL, OP_RINT}))
      return x;
    if (op == OP_FLOOR) return {sgn, round_magnitude(x[62:0], sgn ? KIND_UP : KIND_TRUNC)};
    if (op == OP_CEIL) return {sgn, round_magnitude(x[62:0], sgn ? KIND_TRUNC : KIND_UP)};
    case (mode)
      RM_NEAREST: kind = KIND_NEAREST;
      RM_ZERO:    kind = KIND_TRUNC;
      RM_UP:      kind = sgn ? KIND_TRUNC : KIND_UP;
      default:    kind = sgn ? KIND_UP : KIND_TRUNC;
    endcase
    mag = round_magnitude(x[62:0], kind);
    if (mag == 0) return (mode == RM_DOWN) ? 64'h8000000000000000 : 64'd0;
    return {sgn, mag};
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_rounded.size() == 0)
          report_mismatch("unexpected result", m_axis_tdata, 64'd0);
        else begin
          if (m_axis_tdata !== expected_rounded[0])
            report_mismatch("result_bits", m_axis_tdata, expected_rounded[0]);
          void'(expected_rounded.pop_front());
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("Regression FAIL");
      $finish;
    end
  end

  // Send one operand; valid stays high into the next transaction when there is no gap.
  task automatic send_operand(logic [1:0] op, logic [63:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, x, op};
    expected_rounded.push_back(rounded_value(op, x, mode_shadow));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_rounded.size() != 0) @(posedge clk_i);
    repeat (STAGES + 4) @(posedge clk_i);
  endtask

  task automatic write_mode(logic [1:0] mode);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mode_shadow = mode;
  endtask

  // Random operation, with the unused opcode now and then.
  function automatic logic [1:0] random_opcode();
    if ($urandom_range(15) == 0) return OP_UNUSED;
    return 2'($urandom_range(2));
  endfunction

  // Random operand biased toward exponents near the integer boundary.
  function automatic logic [63:0] random_operand();
    logic [63:0] x;
    x = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1: x[62:52] = 11'($urandom_range(1000, 1022));
      2:    x[62:52] = 11'($urandom_range(1075, 1100));
      3:    x[62:52] = $urandom_range(1) ? EXP_ALL1 : 11'd0;
      4:    x[51:0] = x[51:0] & ({52{1'b1}} << $urandom_range(52));
      9:    ;
      default: x[62:52] = 11'($urandom_range(1023, 1074));
    endcase
    if ($urandom_range(3) == 0) x[62:52] = 11'($urandom_range(1021, 1023));
    return x;
  endfunction

  // Zeros, halves, ties, boundaries, NaN, infinity and the unused opcode.
  task automatic test_special_values();
    logic [63:0] vals[12];
    vals = '{64'h0, 64'h8000000000000000, 64'h3FE0000000000000, 64'hBFE0000000000000,
             64'h3FF8000000000000, 64'h4004000000000000, 64'h3FEFFFFFFFFFFFFF,
             64'h432FFFFFFFFFFFFF, 64'h4330000000000000, 64'h7FF0000000000000,
             64'hFFF8000000000001, 64'h0000000000000001};
    foreach (vals[i]) begin
      send_operand(OP_FLOOR, vals[i]);
      send_operand(OP_CEIL, vals[i] ^ 64'h8000000000000000);
    end
    send_operand(OP_UNUSED, 64'hBFF8000000000000);
  endtask

  task automatic test_rint_modes();
    logic [1:0] modes[4];
    modes = '{RM_UP, RM_DOWN, RM_ZERO, RM_NEAREST};
    foreach (modes[m]) begin
      write_mode(modes[m]);
      send_operand(OP_RINT, 64'hBFE0000000000000);
      send_operand(OP_RINT, 64'h8000000000000000);
      send_operand(OP_RINT, 64'h400C000000000000);
      send_operand(OP_RINT, 64'hC004000000000000);
    end
  endtask

  task automatic test_random_ops(int unsigned count, int unsigned sidle, int unsigned rstall);
    drain_results();
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    write_mode(2'($urandom_range(3)));
    repeat (count) send_operand(random_opcode(), random_operand());
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    mode_shadow = RM_NEAREST;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_values();
    test_rint_modes();
    test_random_ops(105, 0, 0);
    test_random_ops(100, 82, 0);
    test_random_ops(100, 0, 82);
    test_random_ops(100, 33, 33);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_results();
    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
